[rtl/core/mck_pkg.sv]
// shared types, constants and the morse code table for the character keyer
// no dependencies; imported by every module of the keyer
package mck_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned DUR_W  = 11;
   localparam int unsigned WGT_W  = 7;
   localparam int unsigned UNITS_W = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTING   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_UNITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_UNITS   = 2'd2;

   localparam logic [WGT_W-1:0]   WEIGHTING_RESET    = 7'd50;
   localparam logic [UNITS_W-1:0] LETTER_UNITS_RESET = 4'd3;
   localparam logic [UNITS_W-1:0] WORD_UNITS_RESET   = 4'd7;

   localparam logic [DUR_W-1:0] DIT_TOTAL     = 11'd200;
   localparam logic [DUR_W-1:0] DAH_TOTAL     = 11'd400;
   localparam logic [DUR_W-1:0] HALF_SPACE    = 11'd50;
   localparam logic [DUR_W-1:0] INVALID_PAUSE = 11'd50;

   localparam logic [CHAR_W-1:0] CHAR_SPACE_LOW = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_BACKQUOTE = 8'h60;
   localparam logic [CHAR_W-1:0] CHAR_BAR       = 8'h7C;
   localparam logic [CHAR_W-1:0] CHAR_OUT_LIMIT = 8'h7B;
   localparam logic [CHAR_W-1:0] CASE_OFFSET    = 8'h20;

   localparam logic [7:0] CODE_EMPTY     = 8'h00;
   localparam logic [7:0] CODE_STOP_ONLY = 8'h80;

   // entry bits from msb down: 0 dit, 1 dah, lowest set bit is the stop mark
   localparam logic [7:0] MORSE_TABLE [64] = '{
      8'h80, 8'hCE, 8'h4C, 8'h00, 8'h13, 8'h00, 8'h44, 8'h7A,
      8'hB4, 8'hB6, 8'h8B, 8'h54, 8'hCE, 8'h86, 8'h56, 8'h94,
      8'hFC, 8'h7C, 8'h3C, 8'h1C, 8'h0C, 8'h04, 8'h84, 8'hC4,
      8'hE4, 8'hF4, 8'hE2, 8'hAA, 8'h54, 8'h8C, 8'h16, 8'h32,
      8'h6A, 8'h60, 8'h88, 8'hA8, 8'h90, 8'h40, 8'h28, 8'hD0,
      8'h08, 8'h20, 8'h78, 8'hB0, 8'h48, 8'hE0, 8'hA0, 8'hF0,
      8'h68, 8'hD8, 8'h50, 8'h10, 8'hC0, 8'h30, 8'h18, 8'h70,
      8'h98, 8'hB8, 8'hC8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6C
   };

   typedef enum logic [1:0] {
      KIND_INVALID,
      KIND_HALF,
      KIND_WORD,
      KIND_ELEMENTS
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] code;
   } decode_type;

   typedef struct packed {
      logic [DUR_W-1:0] dit_on;
      logic [DUR_W-1:0] dit_off;
      logic [DUR_W-1:0] dah_on;
      logic [DUR_W-1:0] dah_off;
      logic [DUR_W-1:0] letter_gap;
      logic [DUR_W-1:0] word_gap;
   } timing_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INVALID,
      S_HALF,
      S_WORD,
      S_ON,
      S_OFF,
      S_LETTER
   } state_type;

   // x * 100 as shifts and adds
   function automatic logic [DUR_W-1:0] times_100(input logic [UNITS_W-1:0] x);
      logic [DUR_W-1:0] wide;
      wide = {{(DUR_W-UNITS_W){1'b0}}, x};
      return (wide << 6) + (wide << 5) + (wide << 2);
   endfunction

endpackage

[rtl/core/morse_character_keyer.sv]
// top level of the morse character keyer
// depends on mck_pkg, mck_decode, mck_timing, mck_seq
//
// takes one ascii character per item and returns its key timing as a series
// of result items (key_down, duration in hundredths of a dit, last_of_char).
// lower case is folded to upper case and looked up in a 64-entry morse table;
// each element gives a key-down then a key-up period, and every valid character
// ends with a key-up letter space flagged last_of_char. a space sends a word gap
// first, '|' a half space of 50, and anything without a code a single key-up
// of 50. a character has at most seven elements plus the letter space; the
// sequencer loads one period per cycle into the output register while it is
// free and holds while a result waits with rsp_ready low. the next character is
// accepted as soon as the last period is loaded into the output register.
// configuration writes take effect on the next clock and are meant for idle
// time only.
module morse_character_keyer (
   input  logic                            clock,
   input  logic                            reset,
   // character input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_char_code,
   // period output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_key_down,
   output logic [mck_pkg::DUR_W-1:0]       rsp_duration,
   output logic                            rsp_last_of_char,
   // configuration writes
   input  logic                            csr_we,
   input  logic [mck_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mck_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mck_pkg::*;

   decode_type dec;
   timing_type timing;

   // classify the character and fetch its code pattern
   mck_decode u_decode (
      .char_code (req_char_code),
      .dec       (dec)
   );

   // weighting and gap registers, period lengths derived from them
   mck_timing u_timing (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .timing    (timing)
   );

   // code shift register and output register, one period per cycle unless the output stalls
   mck_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .dec              (dec),
      .timing           (timing),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_key_down     (rsp_key_down),
      .rsp_duration     (rsp_duration),
      .rsp_last_of_char (rsp_last_of_char)
   );

endmodule

[rtl/core/mck_decode.sv]
// character classifier: case folding and morse table lookup
// depends on mck_pkg
module mck_decode (
   input  logic [7:0]          char_code,
   output mck_pkg::decode_type dec
);
   import mck_pkg::*;

   logic [CHAR_W-1:0] folded;
   logic [5:0]        idx;
   logic [7:0]        entry;

   always_comb begin
      folded = (char_code > CHAR_BACKQUOTE) ? (char_code - CASE_OFFSET) : char_code;
      idx    = folded[5:0] - CHAR_SPACE_LOW[5:0];
      entry  = MORSE_TABLE[idx];

      dec.code = entry;
      if (char_code == CHAR_BAR) begin
         dec.kind = KIND_HALF;
      end else if (char_code < CHAR_SPACE_LOW || char_code >= CHAR_OUT_LIMIT ||
                   char_code == CHAR_BACKQUOTE) begin
         dec.kind = KIND_INVALID;
      end else if (entry == CODE_EMPTY) begin
         dec.kind = KIND_INVALID;
      end else if (entry == CODE_STOP_ONLY) begin
         dec.kind = KIND_WORD;
      end else begin
         dec.kind = KIND_ELEMENTS;
      end
   end

endmodule

[rtl/core/mck_timing.sv]
// configuration registers and the period lengths derived from them
// depends on mck_pkg
module mck_timing (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mck_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mck_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mck_pkg::timing_type                timing
);
   import mck_pkg::*;

   logic [WGT_W-1:0]   weight_ff, weight_in;
   logic [UNITS_W-1:0] letter_ff, letter_in;
   logic [UNITS_W-1:0] word_ff, word_in;

   logic [DUR_W-1:0]   dit_raw, dah_raw, wide_w;
   logic [UNITS_W:0]   need;
   logic [UNITS_W:0]   word_diff;

   always_comb begin
      weight_in = weight_ff;
      letter_in = letter_ff;
      word_in   = word_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WEIGHTING:    weight_in = csr_wdata[WGT_W-1:0];
            CSR_LETTER_UNITS: letter_in = csr_wdata[UNITS_W-1:0];
            CSR_WORD_UNITS:   word_in   = csr_wdata[UNITS_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHTING_RESET;
         letter_ff <= LETTER_UNITS_RESET;
         word_ff   <= WORD_UNITS_RESET;
      end else begin
         weight_ff <= weight_in;
         letter_ff <= letter_in;
         word_ff   <= word_in;
      end
   end

   always_comb begin
      wide_w  = {{(DUR_W-WGT_W){1'b0}}, weight_ff};
      dit_raw = wide_w << 1;
      dah_raw = (wide_w << 2) + (wide_w << 1);

      // heavy weighting clamps the mark to the element total
      timing.dit_on  = (dit_raw > DIT_TOTAL) ? DIT_TOTAL : dit_raw;
      timing.dah_on  = (dah_raw > DAH_TOTAL) ? DAH_TOTAL : dah_raw;
      timing.dit_off = DIT_TOTAL - timing.dit_on;
      timing.dah_off = DAH_TOTAL - timing.dah_on;

      timing.letter_gap = (letter_ff == '0) ? '0 : times_100(letter_ff - 4'd1);

      need      = {1'b0, letter_ff} + 5'd2;
      word_diff = {1'b0, word_ff} - need;
      timing.word_gap = ({1'b0, word_ff} > need) ?
                        times_100(word_diff[UNITS_W-1:0]) : '0;
   end

endmodule

[rtl/core/mck_seq.sv]
// period sequencer: shifts the morse code out one element per step and
// drives the result output register; depends on mck_pkg
module mck_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mck_pkg::decode_type             dec,
   input  mck_pkg::timing_type             timing,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_key_down,
   output logic [mck_pkg::DUR_W-1:0]       rsp_duration,
   output logic                            rsp_last_of_char
);
   import mck_pkg::*;

   state_type        state_ff, state_in;
   logic [7:0]       code_ff, code_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_key_down_ff, rsp_key_down_in;
   logic [DUR_W-1:0] rsp_duration_ff, rsp_duration_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             out_free;
   logic             emit;
   logic [7:0]       code_shifted;

   assign out_free     = ~rsp_valid_ff | rsp_ready;
   assign code_shifted = {code_ff[6:0], 1'b0};
   assign req_ready    = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      code_in         = code_ff;
      emit            = 1'b0;
      rsp_key_down_in = 1'b0;
      rsp_duration_in = '0;
      rsp_last_in     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               code_in = dec.code;
               unique case (dec.kind)
                  KIND_INVALID:  state_in = S_INVALID;
                  KIND_HALF:     state_in = S_HALF;
                  KIND_WORD:     state_in = S_WORD;
                  KIND_ELEMENTS: state_in = S_ON;
               endcase
            end
         end
         S_INVALID: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_duration_in = INVALID_PAUSE;
               rsp_last_in     = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_HALF: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_duration_in = HALF_SPACE;
               state_in        = S_LETTER;
            end
         end
         S_WORD: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_duration_in = timing.word_gap;
               state_in        = S_LETTER;
            end
         end
         S_ON: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_key_down_in = 1'b1;
               rsp_duration_in = code_ff[7] ? timing.dah_on : timing.dit_on;
               state_in        = S_OFF;
            end
         end
         S_OFF: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_duration_in = code_ff[7] ? timing.dah_off : timing.dit_off;
               code_in         = code_shifted;
               state_in        = (code_shifted == CODE_STOP_ONLY) ? S_LETTER : S_ON;
            end
         end
         S_LETTER: begin
            if (out_free) begin
               emit            = 1'b1;
               rsp_duration_in = timing.letter_gap;
               rsp_last_in     = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      if (emit) begin
         rsp_key_down_ff <= rsp_key_down_in;
         rsp_duration_ff <= rsp_duration_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_down     = rsp_key_down_ff;
   assign rsp_duration     = rsp_duration_ff;
   assign rsp_last_of_char = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start a sequence");

   a_code_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ON || state_ff == S_OFF) |->
      (code_ff != CODE_STOP_ONLY && code_ff != CODE_EMPTY))
      else $error("element state with an exhausted code");

   a_mark_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_key_down_ff) |-> !rsp_last_ff)
      else $error("key-down period flagged as last of character");

   a_mark_bounded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_key_down_ff) |-> (rsp_duration_ff <= DAH_TOTAL))
      else $error("key-down period longer than a dah element");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !emit)
      else $error("output register overwritten while stalled");
`endif

endmodule
